// ----- rtl/core/voxel_lod_downsampler_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the voxel LOD downsampler core
// Shorthands for clocked implications, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef VOXEL_LOD_DOWNSAMPLER_CORE_ASSERT_SVH
`define VOXEL_LOD_DOWNSAMPLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VLD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/vld_pkg.sv -----
// ----------------------------------------------------------------------------
// vld_pkg
// Types and constants shared by the voxel LOD downsampler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vld_pkg;

    localparam int BIN_AW      = 12;
    localparam int BIN_DEPTH   = 4096;
    localparam int PAL_AW      = 8;
    localparam int PAL_ENTRIES = 256;
    localparam int DIV_BITS    = 24;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] MODE_PAL   = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    localparam logic CFG_STEP = 1'b0;
    localparam logic CFG_PAL  = 1'b1;

    typedef struct packed {
        logic [23:0] red;
        logic [23:0] green;
        logic [23:0] blue;
        logic [19:0] ao;
        logic [15:0] count;
        logic [5:0]  mask;
    } bin_t;

    typedef struct packed {
        logic capture;
        logic pal_wr;
        logic add_rd;
        logic add_wr;
        logic clr_wr;
        logic scan_start;
        logic scan_chk;
        logic div_load;
        logic div_step;
        logic pal_start;
        logic pal_sq;
        logic pal_cmp;
        logic out_load;
        logic out_done;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_found;
        logic scan_last;
        logic div_last_bit;
        logic div_last_chan;
        logic pal_empty;
        logic pal_last;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/core/voxel_lod_downsampler_core.sv -----
// ----------------------------------------------------------------------------
// voxel_lod_downsampler_core
// Bins the voxels of one 32-cubed cluster into a coarser level of detail.
// ----------------------------------------------------------------------------
// After reset the block clears its 4096-entry bin memory, one bin a cycle,
// and takes no word until the clear is done. A palette write is done in the
// idle state, and a voxel add does a read-modify-write of the bin memory.
// A drain scans bins from the drain cursor, reading and then checking each
// one. On an occupied bin it runs the shared 24-step divider four times and
// then searches the palette unless it is empty, reading, squaring and
// comparing each entry; with no bin occupied it returns a done word. One
// word is worked on at a time; a finished result waits in the output
// register while the next word is accepted.
`timescale 1ns / 1ps

module voxel_lod_downsampler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pal_slot[7:0], voxel_x[12:8], voxel_y[17:13], voxel_z[22:18],
    // face_mask[28:23], ao_faces[52:29], color[76:53], zero fill above.
    input  logic [79:0] s_tdata,
    // mode[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bin_x[3:0], bin_y[7:4], bin_z[11:8], merged_mask[17:12],
    // merged_ao[41:18], palette_index[49:42], zero fill above.
    output logic [55:0] m_tdata,
    // done_res[0].
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    vld_pkg::cmd_t cmd;
    vld_pkg::sts_t sts;

    logic [3:0]  bin_x;
    logic [3:0]  bin_y;
    logic [3:0]  bin_z;
    logic [5:0]  merged_mask;
    logic [23:0] merged_ao;
    logic [7:0]  palette_index;

    vld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vld_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .pal_slot     (s_tdata[7:0]),
        .voxel_x      (s_tdata[12:8]),
        .voxel_y      (s_tdata[17:13]),
        .voxel_z      (s_tdata[22:18]),
        .face_mask    (s_tdata[28:23]),
        .ao_faces     (s_tdata[52:29]),
        .color        (s_tdata[76:53]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_bin_x    (bin_x),
        .out_bin_y    (bin_y),
        .out_bin_z    (bin_z),
        .out_mask     (merged_mask),
        .out_ao       (merged_ao),
        .out_index    (palette_index),
        .out_done_res (m_tuser)
    );

    assign m_tdata = {6'd0, palette_index, merged_ao, merged_mask, bin_z, bin_y, bin_x};

endmodule

// ----- rtl/core/vld_ram.sv -----
// ----------------------------------------------------------------------------
// vld_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/vld_ctrl.sv -----
// ----------------------------------------------------------------------------
// vld_ctrl
// Sequencer for clearing, voxel adds, bin scans, division and palette search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vld_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic [1:0]    s_tuser,
    output logic          s_tready,
    input  vld_pkg::sts_t sts,
    output vld_pkg::cmd_t cmd
);

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ADD      = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_DIV_LD   = 4'd5;
    localparam logic [3:0] S_DIV_RUN  = 4'd6;
    localparam logic [3:0] S_PAL_RD   = 4'd7;
    localparam logic [3:0] S_PAL_SQ   = 4'd8;
    localparam logic [3:0] S_PAL_CMP  = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;
    localparam logic [3:0] S_OUT_DONE = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (s_tuser)
                        vld_pkg::MODE_PAL:
                        begin
                            cmd.pal_wr = 1'b1;
                        end
                        vld_pkg::MODE_ADD:
                        begin
                            cmd.add_rd = 1'b1;
                            state_next = S_ADD;
                        end
                        vld_pkg::MODE_DRAIN:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                if (sts.scan_found)
                begin
                    state_next = S_DIV_LD;
                end
                else if (sts.scan_last)
                begin
                    state_next = S_OUT_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_DIV_LD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last_bit)
                begin
                    if (!sts.div_last_chan)
                    begin
                        state_next = S_DIV_LD;
                    end
                    else if (sts.pal_empty)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.pal_start = 1'b1;
                        state_next    = S_PAL_RD;
                    end
                end
            end
            S_PAL_RD:
            begin
                state_next = S_PAL_SQ;
            end
            S_PAL_SQ:
            begin
                cmd.pal_sq = 1'b1;
                state_next = S_PAL_CMP;
            end
            S_PAL_CMP:
            begin
                cmd.pal_cmp = 1'b1;
                state_next  = sts.pal_last ? S_OUT : S_PAL_RD;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_OUT_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/vld_datapath.sv -----
// ----------------------------------------------------------------------------
// vld_datapath
// Bin and palette stores, bin update, shared divider, nearest-colour search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vld_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  vld_pkg::cmd_t cmd,
    output vld_pkg::sts_t sts,
    input  logic [7:0]    pal_slot,
    input  logic [4:0]    voxel_x,
    input  logic [4:0]    voxel_y,
    input  logic [4:0]    voxel_z,
    input  logic [5:0]    face_mask,
    input  logic [23:0]   ao_faces,
    input  logic [23:0]   color,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [8:0]    cfg_data,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [3:0]    out_bin_x,
    output logic [3:0]    out_bin_y,
    output logic [3:0]    out_bin_z,
    output logic [5:0]    out_mask,
    output logic [23:0]   out_ao,
    output logic [7:0]    out_index,
    output logic          out_done_res
);

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_AO    = 2'd3;

    localparam logic [4:0] DIV_LAST = 5'(vld_pkg::DIV_BITS - 1);

    logic [1:0]  step_reg;
    logic [8:0]  palcnt_reg;

    logic [vld_pkg::BIN_AW-1:0] key_reg;
    logic [3:0]  top_reg;
    logic [23:0] color_reg;
    logic [5:0]  mask_reg;

    logic [vld_pkg::BIN_AW-1:0] clr_cnt_reg;
    logic [vld_pkg::BIN_AW-1:0] scan_key_reg;
    logic [vld_pkg::BIN_AW-1:0] scanned_reg;
    logic [vld_pkg::BIN_AW-1:0] cursor_reg;
    vld_pkg::bin_t              hold_reg;

    logic [1:0]  chan_reg;
    logic [4:0]  bit_reg;
    logic [16:0] rem_reg;
    logic [23:0] dvd_reg;
    logic [23:0] quo_reg;
    logic [7:0]  avg_r_reg;
    logic [7:0]  avg_g_reg;
    logic [7:0]  avg_b_reg;
    logic [3:0]  avg_ao_reg;

    logic [7:0]  pal_idx_reg;
    logic [15:0] sq_r_reg;
    logic [15:0] sq_g_reg;
    logic [15:0] sq_b_reg;
    logic [18:0] best_reg;
    logic [7:0]  pick_reg;

    logic        out_valid_reg;

    logic [1:0]  step_eff;
    logic [4:0]  bx5;
    logic [4:0]  by5;
    logic [4:0]  bz5;
    logic [vld_pkg::BIN_AW-1:0] key_in;
    logic [3:0]  top_in;

    logic                       bin_we;
    logic [vld_pkg::BIN_AW-1:0] bin_waddr;
    vld_pkg::bin_t              bin_wdata;
    logic [vld_pkg::BIN_AW-1:0] bin_raddr;
    vld_pkg::bin_t              bin_rdata;
    vld_pkg::bin_t              bin_upd;

    logic [23:0] pal_rdata;
    logic [16:0] trial;
    logic        qbit;
    logic [23:0] quo_next;
    logic [8:0]  pal_limit;
    logic [7:0]  dr;
    logic [7:0]  dg;
    logic [7:0]  db;
    logic [18:0] pal_dist;

    assign step_eff = (step_reg == 2'd0) ? 2'd1 : step_reg;
    assign bx5      = voxel_x >> step_eff;
    assign by5      = voxel_y >> step_eff;
    assign bz5      = voxel_z >> step_eff;
    assign key_in   = {bz5[3:0], by5[3:0], bx5[3:0]};

    always_comb
    begin
        top_in = 4'd0;
        for (int f = 0; f < 6; f++)
        begin
            if (ao_faces[4*f +: 4] > top_in)
            begin
                top_in = ao_faces[4*f +: 4];
            end
        end
    end

    // Saturated bins keep their sums and count but still collect face masks.
    always_comb
    begin
        bin_upd      = bin_rdata;
        bin_upd.mask = bin_rdata.mask | mask_reg;
        if (bin_rdata.count != vld_pkg::COUNT_MAX)
        begin
            bin_upd.red   = bin_rdata.red + {16'd0, color_reg[7:0]};
            bin_upd.green = bin_rdata.green + {16'd0, color_reg[15:8]};
            bin_upd.blue  = bin_rdata.blue + {16'd0, color_reg[23:16]};
            bin_upd.ao    = bin_rdata.ao + {16'd0, top_reg};
            bin_upd.count = bin_rdata.count + 16'd1;
        end
    end

    always_comb
    begin
        bin_we    = 1'b0;
        bin_waddr = key_reg;
        bin_wdata = '0;
        if (cmd.clr_wr)
        begin
            bin_we    = 1'b1;
            bin_waddr = clr_cnt_reg;
        end
        else if (cmd.add_wr)
        begin
            bin_we    = 1'b1;
            bin_wdata = bin_upd;
        end
        else if (cmd.scan_chk && sts.scan_found)
        begin
            bin_we    = 1'b1;
            bin_waddr = scan_key_reg;
        end
    end

    assign bin_raddr = cmd.add_rd ? key_in : scan_key_reg;

    vld_ram #(
        .WIDTH ($bits(vld_pkg::bin_t)),
        .DEPTH (vld_pkg::BIN_DEPTH)
    ) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    vld_ram #(
        .WIDTH (24),
        .DEPTH (vld_pkg::PAL_ENTRIES)
    ) u_pal_ram (
        .clk   (clk),
        .we    (cmd.pal_wr),
        .waddr (pal_slot),
        .wdata (color),
        .raddr (pal_idx_reg),
        .rdata (pal_rdata)
    );

    assign trial    = {rem_reg[15:0], dvd_reg[23]};
    assign qbit     = (trial >= {1'b0, hold_reg.count});
    assign quo_next = {quo_reg[22:0], qbit};

    assign pal_limit = (palcnt_reg > 9'(vld_pkg::PAL_ENTRIES))
                       ? 9'(vld_pkg::PAL_ENTRIES) : palcnt_reg;

    assign dr   = (pal_rdata[7:0] >= avg_r_reg) ? pal_rdata[7:0] - avg_r_reg
                                                : avg_r_reg - pal_rdata[7:0];
    assign dg   = (pal_rdata[15:8] >= avg_g_reg) ? pal_rdata[15:8] - avg_g_reg
                                                 : avg_g_reg - pal_rdata[15:8];
    assign db   = (pal_rdata[23:16] >= avg_b_reg) ? pal_rdata[23:16] - avg_b_reg
                                                  : avg_b_reg - pal_rdata[23:16];
    assign pal_dist = {3'd0, sq_r_reg} + {3'd0, sq_g_reg} + {3'd0, sq_b_reg};

    assign sts.clr_last      = &clr_cnt_reg;
    assign sts.scan_found    = (bin_rdata.count != 16'd0);
    assign sts.scan_last     = &scanned_reg;
    assign sts.div_last_bit  = (bit_reg == DIV_LAST);
    assign sts.div_last_chan = (chan_reg == CH_AO);
    assign sts.pal_empty     = (pal_limit == 9'd0);
    assign sts.pal_last      = ({1'b0, pal_idx_reg} + 9'd1 == pal_limit);
    assign sts.out_free      = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd1;
            palcnt_reg    <= 9'd0;
            clr_cnt_reg   <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == vld_pkg::CFG_STEP)
            begin
                step_reg <= cfg_data[1:0];
            end
            if (cfg_we && cfg_index == vld_pkg::CFG_PAL)
            begin
                palcnt_reg <= cfg_data;
            end
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.scan_chk && sts.scan_found)
            begin
                cursor_reg <= scan_key_reg + 1'b1;
            end
            else if (cmd.out_done)
            begin
                cursor_reg <= '0;
            end
            if (cmd.out_load || cmd.out_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg   <= key_in;
            top_reg   <= top_in;
            color_reg <= color;
            mask_reg  <= face_mask;
        end
        if (cmd.scan_start)
        begin
            scan_key_reg <= cursor_reg;
            scanned_reg  <= '0;
            pick_reg     <= 8'd0;
            chan_reg     <= CH_RED;
        end
        else if (cmd.scan_chk)
        begin
            if (sts.scan_found)
            begin
                hold_reg <= bin_rdata;
            end
            else
            begin
                scan_key_reg <= scan_key_reg + 1'b1;
                scanned_reg  <= scanned_reg + 1'b1;
            end
        end
        if (cmd.div_load)
        begin
            rem_reg <= 17'd0;
            quo_reg <= 24'd0;
            bit_reg <= 5'd0;
            unique case (chan_reg)
                CH_RED:   dvd_reg <= hold_reg.red;
                CH_GREEN: dvd_reg <= hold_reg.green;
                CH_BLUE:  dvd_reg <= hold_reg.blue;
                default:  dvd_reg <= {4'd0, hold_reg.ao};
            endcase
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? trial - {1'b0, hold_reg.count} : trial;
            dvd_reg <= {dvd_reg[22:0], 1'b0};
            quo_reg <= quo_next;
            bit_reg <= bit_reg + 5'd1;
            if (sts.div_last_bit)
            begin
                chan_reg <= chan_reg + 2'd1;
                unique case (chan_reg)
                    CH_RED:   avg_r_reg  <= quo_next[7:0];
                    CH_GREEN: avg_g_reg  <= quo_next[7:0];
                    CH_BLUE:  avg_b_reg  <= quo_next[7:0];
                    default:  avg_ao_reg <= quo_next[3:0];
                endcase
            end
        end
        if (cmd.pal_start)
        begin
            pal_idx_reg <= 8'd0;
            best_reg    <= '1;
        end
        if (cmd.pal_sq)
        begin
            sq_r_reg <= dr * dr;
            sq_g_reg <= dg * dg;
            sq_b_reg <= db * db;
        end
        if (cmd.pal_cmp)
        begin
            if (pal_dist < best_reg)
            begin
                best_reg <= pal_dist;
                pick_reg <= pal_idx_reg;
            end
            pal_idx_reg <= pal_idx_reg + 8'd1;
        end
        if (cmd.out_load)
        begin
            out_bin_x    <= scan_key_reg[3:0];
            out_bin_y    <= scan_key_reg[7:4];
            out_bin_z    <= scan_key_reg[11:8];
            out_mask     <= hold_reg.mask;
            out_ao       <= {6{avg_ao_reg}};
            out_index    <= (pal_dist < best_reg && cmd.pal_cmp) ? pal_idx_reg : pick_reg;
            out_done_res <= 1'b0;
        end
        else if (cmd.out_done)
        begin
            out_bin_x    <= 4'd0;
            out_bin_y    <= 4'd0;
            out_bin_z    <= 4'd0;
            out_mask     <= 6'd0;
            out_ao       <= 24'd0;
            out_index    <= 8'd0;
            out_done_res <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/vld_checker.sv -----
// ----------------------------------------------------------------------------
// vld_checker
// Port-level checks on the voxel LOD downsampler core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voxel_lod_downsampler_core_assert.svh"

module vld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result word stays on the bus.
    `VLD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // A done word carries nothing else.
    `VLD_ASSERT_SAME(a_done_zero, m_tvalid && m_tuser, m_tdata == 56'd0)
    // The first, second and sixth AO nibbles of a result carry the same average.
    `VLD_ASSERT_SAME(a_ao_repl, m_tvalid, m_tdata[21:18] == m_tdata[25:22] && m_tdata[21:18] == m_tdata[41:38])
    // A voxel add or a drain holds off the next word: ready is low in the cycle after it is accepted.
    `VLD_ASSERT_NEXT(a_busy, s_tvalid && s_tready && (s_tuser == vld_pkg::MODE_ADD || s_tuser == vld_pkg::MODE_DRAIN), !s_tready)

endmodule

bind voxel_lod_downsampler_core vld_checker u_vld_checker (.*);

// ----- tb/voxel_lod_downsampler_core_tb.sv -----
// ----------------------------------------------------------------------------
// voxel_lod_downsampler_core_tb
// Self-checking testbench for the voxel LOD downsampler core. A directed table
// covers reset, extremes, the ignored mode, step and palette clamping, and a
// second phase of random rounds (each with its own step and palette size) adds
// voxels and drains every bin. The table or a behavioral predictor gives each drained word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_lod_downsampler_core_tb;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int STALL_LIMIT = 60000;
    localparam int SETTLE_CYCLES = 24;
    localparam int ROUNDS = 10;
    localparam int ROUND_WORDS = 80;

    typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic [3:0]  bx;
        logic [3:0]  by;
        logic [3:0]  bz;
        logic [5:0]  mask;
        logic [23:0] ao;
        logic [7:0]  pidx;
        logic        done;
    } bin_report_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  mode;
        logic [79:0] data;
        logic        cfg_idx;
        logic [8:0]  cfg_val;
        bit          typed;
        bin_report_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    voxel_lod_downsampler_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state.
    logic [23:0] pal_mem [vld_pkg::PAL_ENTRIES];
    logic [23:0] red_acc [vld_pkg::BIN_DEPTH];
    logic [23:0] grn_acc [vld_pkg::BIN_DEPTH];
    logic [23:0] blu_acc [vld_pkg::BIN_DEPTH];
    logic [19:0] ao_acc [vld_pkg::BIN_DEPTH];
    logic [15:0] vox_cnt [vld_pkg::BIN_DEPTH];
    logic [5:0]  mask_acc [vld_pkg::BIN_DEPTH];
    logic [11:0] cursor;
    logic [1:0]  step_reg;
    logic [8:0]  pal_cnt_reg;

    bin_report_t pending_bins [$];
    stim_row_t   rows [$];

    int  errors = 0;
    int  words_in;
    int  reports_out = 0;
    int  drains_sent;
    int  idle_cycles = 0;
    bit  calm;
    int  ready_wait = 0;

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [79:0] pack_word(input logic [7:0] slot, input logic [4:0] x,
                                              input logic [4:0] y, input logic [4:0] z,
                                              input logic [5:0] mask, input logic [23:0] ao,
                                              input logic [23:0] color);
        return {3'b0, color, ao, mask, z, y, x, slot};
    endfunction

    function automatic logic [7:0] nearest_color(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        int unsigned lim;
        int unsigned best;
        int unsigned d;
        int dr;
        int dg;
        int db;
        logic [7:0] pick;
        lim = (int'(pal_cnt_reg) > vld_pkg::PAL_ENTRIES) ? vld_pkg::PAL_ENTRIES
                                                        : int'(pal_cnt_reg);
        best = 32'hFFFF_FFFF;
        pick = 8'd0;
        for (int p = 0; p < lim; p++)
        begin
            dr = int'(pal_mem[p][7:0]) - int'(r);
            dg = int'(pal_mem[p][15:8]) - int'(g);
            db = int'(pal_mem[p][23:16]) - int'(b);
            d = dr * dr + dg * dg + db * db;
            if (d < best)
            begin
                best = d;
                pick = p[7:0];
            end
        end
        return pick;
    endfunction

    function automatic bit apply_word(input logic [1:0] mode, input logic [79:0] data,
                                      output bin_report_t rep);
        logic [1:0]  sh;
        logic [11:0] key;
        logic [3:0]  top;
        logic [3:0]  avg;
        logic [15:0] n;
        rep = '0;
        if (mode == vld_pkg::MODE_PAL)
        begin
            pal_mem[data[7:0]] = data[76:53];
            return 0;
        end
        if (mode == vld_pkg::MODE_ADD)
        begin
            sh = (step_reg == 2'd0) ? 2'd1 : step_reg;
            key = {4'(data[22:18] >> sh), 4'(data[17:13] >> sh), 4'(data[12:8] >> sh)};
            top = 4'd0;
            for (int f = 0; f < 6; f++)
                if (data[29 + 4 * f +: 4] > top)
                    top = data[29 + 4 * f +: 4];
            if (vox_cnt[key] < vld_pkg::COUNT_MAX)
            begin
                red_acc[key] = red_acc[key] + {16'd0, data[60:53]};
                grn_acc[key] = grn_acc[key] + {16'd0, data[68:61]};
                blu_acc[key] = blu_acc[key] + {16'd0, data[76:69]};
                ao_acc[key] = ao_acc[key] + {16'd0, top};
                vox_cnt[key] = vox_cnt[key] + 16'd1;
            end
            mask_acc[key] = mask_acc[key] | data[28:23];
            return 0;
        end
        if (mode == vld_pkg::MODE_DRAIN)
        begin
            for (int i = 0; i < vld_pkg::BIN_DEPTH; i++)
            begin
                key = cursor + i[11:0];
                n = vox_cnt[key];
                if (n != 0)
                begin
                    avg = 4'(ao_acc[key] / n);
                    rep.bx = key[3:0];
                    rep.by = key[7:4];
                    rep.bz = key[11:8];
                    rep.mask = mask_acc[key];
                    rep.ao = {6{avg}};
                    rep.pidx = nearest_color(8'(red_acc[key] / n), 8'(grn_acc[key] / n),
                                             8'(blu_acc[key] / n));
                    red_acc[key] = 24'd0;
                    grn_acc[key] = 24'd0;
                    blu_acc[key] = 24'd0;
                    ao_acc[key] = 20'd0;
                    vox_cnt[key] = 16'd0;
                    mask_acc[key] = 6'd0;
                    cursor = key + 12'd1;
                    return 1;
                end
            end
            rep.done = 1'b1;
            cursor = 12'd0;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit bins_left();
        for (int i = 0; i < vld_pkg::BIN_DEPTH; i++)
            if (vox_cnt[i] != 0)
                return 1;
        return 0;
    endfunction

    // Called and left at a rising edge.
    task automatic send_word(input logic [1:0] mode, input logic [79:0] data,
                             input bit typed, input bin_report_t want);
        int gap;
        bit ok;
        bin_report_t rep;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= data;
        forever
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
            if (ok)
                break;
        end
        words_in++;
        if (mode == vld_pkg::MODE_DRAIN)
            drains_sent++;
        if (apply_word(mode, data, rep))
            pending_bins.insert(pending_bins.size(), typed ? want : rep);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        s_tvalid <= 1'b0;
        while (pending_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == vld_pkg::CFG_STEP)
            step_reg = val[1:0];
        else
            pal_cnt_reg = val;
    endtask

    function automatic void add_row(input logic [1:0] mode, input logic [79:0] data,
                                    input bit typed, input bin_report_t want);
        stim_row_t r;
        r.kind = ROW_WORD;
        r.mode = mode;
        r.data = data;
        r.cfg_idx = 1'b0;
        r.cfg_val = 9'd0;
        r.typed = typed;
        r.want = want;
        rows.insert(rows.size(), r);
    endfunction

    function automatic void cfg_row(input logic idx, input logic [8:0] val);
        stim_row_t r;
        r = '{ROW_CFG, MODE_NONE, '0, idx, val, 0, '0};
        rows.insert(rows.size(), r);
    endfunction

    function automatic bin_report_t bin_of(input logic [3:0] x, input logic [3:0] y,
                                           input logic [3:0] z, input logic [5:0] m,
                                           input logic [23:0] ao);
        return '{x, y, z, m, ao, 8'd0, 1'b0};
    endfunction

    // Result checking and the watchdog.
    always @(negedge clk)
    begin
        bin_report_t got;
        bin_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            reports_out++;
            got = '{m_tdata[3:0], m_tdata[7:4], m_tdata[11:8], m_tdata[17:12],
                    m_tdata[41:18], m_tdata[49:42], m_tuser};
            if (pending_bins.size() == 0)
                report_mismatch("unexpected word", longint'(got), 64'd0);
            else
            begin
                want = pending_bins.pop_front();
                if (got.bx != want.bx) report_mismatch("bin_x", got.bx, want.bx);
                if (got.by != want.by) report_mismatch("bin_y", got.by, want.by);
                if (got.bz != want.bz) report_mismatch("bin_z", got.bz, want.bz);
                if (got.mask != want.mask) report_mismatch("merged_mask", got.mask, want.mask);
                if (got.ao != want.ao) report_mismatch("merged_ao", got.ao, want.ao);
                if (got.pidx != want.pidx)
                    report_mismatch("palette_index", got.pidx, want.pidx);
                if (got.done != want.done) report_mismatch("done_res", got.done, want.done);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The ready side draws a new wait after every accepted result word.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ready_wait = $urandom_range(0, 6);
        if (calm)
            ready_wait = 0;
        if (ready_wait > 0)
        begin
            m_tready <= 1'b0;
            ready_wait--;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        bin_report_t none;
        bin_report_t done_rep;
        logic [1:0] steps [ROUNDS] = '{1, 2, 3, 0, 1, 3, 2, 1, 3, 2};
        int pal_sizes [ROUNDS] = '{16, 256, 0, 1, 511, 40, 8, 255, 2, 100};
        int pick;
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
        clk = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= vld_pkg::MODE_PAL;
        cfg_we <= 1'b0;
        cfg_index <= vld_pkg::CFG_STEP;
        cfg_data <= '0;
        words_in = 0;
        drains_sent = 0;
        calm = 0;
        for (int i = 0; i < vld_pkg::BIN_DEPTH; i++)
        begin
            red_acc[i] = 24'd0;
            grn_acc[i] = 24'd0;
            blu_acc[i] = 24'd0;
            ao_acc[i] = 20'd0;
            vox_cnt[i] = 16'd0;
            mask_acc[i] = 6'd0;
        end
        cursor = 12'd0;
        step_reg = 2'd1;
        pal_cnt_reg = 9'd0;
        none = '0;
        done_rep = '0;
        done_rep.done = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every palette entry gets a colour first, so no search reads an unwritten one.
        for (int p = 0; p < vld_pkg::PAL_ENTRIES; p++)
            send_word(vld_pkg::MODE_PAL, pack_word(p[7:0], 5'd0, 5'd0, 5'd0, 6'd0, 24'd0,
                                                   24'($urandom())), 0, none);

        add_row(vld_pkg::MODE_DRAIN, '0, 1, done_rep);
        add_row(vld_pkg::MODE_ADD, pack_word(8'hFF, 5'd31, 5'd31, 5'd31, 6'h3F, 24'hFFFFFF,
                                             24'hFFFFFF), 0, none);
        add_row(vld_pkg::MODE_ADD, pack_word(8'h00, 5'd0, 5'd0, 5'd0, 6'h00, 24'h000000,
                                             24'h000000), 0, none);
        add_row(vld_pkg::MODE_ADD, pack_word(8'h00, 5'd1, 5'd0, 5'd0, 6'h15, 24'hF00000,
                                             24'h000000), 0, none);
        add_row(vld_pkg::MODE_DRAIN, '0, 1, bin_of(4'd0, 4'd0, 4'd0, 6'h15, 24'h777777));
        add_row(vld_pkg::MODE_DRAIN, '0, 1, bin_of(4'd15, 4'd15, 4'd15, 6'h3F, 24'hFFFFFF));
        add_row(vld_pkg::MODE_DRAIN, '0, 1, done_rep);
        add_row(MODE_NONE, {80{1'b1}}, 0, none);
        add_row(vld_pkg::MODE_DRAIN, '0, 1, done_rep);
        add_row(vld_pkg::MODE_PAL, pack_word(8'h00, 5'd0, 5'd0, 5'd0, 6'd0, 24'd0,
                                             24'h000000), 0, none);
        add_row(vld_pkg::MODE_PAL, pack_word(8'hFF, 5'd0, 5'd0, 5'd0, 6'd0, 24'd0,
                                             24'hFFFFFF), 0, none);
        cfg_row(vld_pkg::CFG_PAL, 9'd300);
        add_row(vld_pkg::MODE_ADD, pack_word(8'h00, 5'd5, 5'd6, 5'd7, 6'h2A, 24'h123456,
                                             24'h123456), 0, none);
        add_row(vld_pkg::MODE_DRAIN, '0, 0, none);
        cfg_row(vld_pkg::CFG_STEP, 9'd0);
        add_row(vld_pkg::MODE_ADD, pack_word(8'h00, 5'd31, 5'd0, 5'd16, 6'h01, 24'h0F0F0F,
                                             24'hFFFFFF), 0, none);
        add_row(vld_pkg::MODE_DRAIN, '0, 0, none);
        cfg_row(vld_pkg::CFG_STEP, 9'd3);
        add_row(vld_pkg::MODE_ADD, pack_word(8'h00, 5'd31, 5'd31, 5'd31, 6'h20, 24'hABCDEF,
                                             24'h808080), 0, none);
        add_row(vld_pkg::MODE_ADD, pack_word(8'h00, 5'd24, 5'd30, 5'd25, 6'h04, 24'h010203,
                                             24'h102030), 0, none);
        add_row(vld_pkg::MODE_DRAIN, '0, 0, none);
        add_row(vld_pkg::MODE_DRAIN, '0, 1, done_rep);
        cfg_row(vld_pkg::CFG_STEP, 9'd2);
        cfg_row(vld_pkg::CFG_PAL, 9'd1);
        add_row(vld_pkg::MODE_ADD, pack_word(8'h00, 5'd17, 5'd9, 5'd3, 6'h3F, 24'h999999,
                                             24'h00FF00), 0, none);
        add_row(vld_pkg::MODE_DRAIN, '0, 0, none);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            else
                send_word(rows[i].mode, rows[i].data, rows[i].typed, rows[i].want);
        end

        for (int r = 0; r < ROUNDS; r++)
        begin
            write_reg(vld_pkg::CFG_STEP, {7'd0, steps[r]});
            write_reg(vld_pkg::CFG_PAL, pal_sizes[r][8:0]);
            calm = (r % 4 == 3);
            for (int k = 0; k < ROUND_WORDS; k++)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 1) == 0)
                begin
                    x = 5'($urandom_range(0, 31));
                    y = 5'($urandom_range(0, 31));
                    z = 5'($urandom_range(0, 31));
                end
                else
                begin
                    x = 5'($urandom_range(0, 7));
                    y = 5'($urandom_range(0, 7));
                    z = 5'($urandom_range(0, 7));
                end
                if (pick < 8)
                    send_word(vld_pkg::MODE_PAL,
                              pack_word(8'($urandom()), 5'd0, 5'd0, 5'd0, 6'd0, 24'd0,
                                        24'($urandom())), 0, none);
                else if (pick < 11)
                    send_word(MODE_NONE, 80'({$urandom(), $urandom(), $urandom()}), 0, none);
                else if (pick < 15)
                    send_word(vld_pkg::MODE_DRAIN, 80'({$urandom(), $urandom(), $urandom()}),
                              0, none);
                else
                    send_word(vld_pkg::MODE_ADD,
                              pack_word(8'($urandom()), x, y, z, 6'($urandom()),
                                        24'($urandom()), 24'($urandom())), 0, none);
            end
            while (bins_left())
                send_word(vld_pkg::MODE_DRAIN, '0, 0, none);
            send_word(vld_pkg::MODE_DRAIN, '0, 0, none);
        end
        calm = 0;
        s_tvalid <= 1'b0;

        while (pending_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words (%0d drains) and checked %0d drained bins.",
                 words_in, drains_sent, reports_out);
        $display("The random part ran %0d rounds, each with its own step and palette size.",
                 ROUNDS);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/vld_pkg.sv
rtl/core/vld_ram.sv
rtl/core/vld_ctrl.sv
rtl/core/vld_datapath.sv
rtl/core/voxel_lod_downsampler_core.sv
rtl/core/vld_checker.sv
tb/voxel_lod_downsampler_core_tb.sv
